[sv/lrd_pkg.sv]
package lrd_pkg;

  // Grid sides are taken from the 13-bit registers and clamped to 1..MAX_SIDE.
  localparam int unsigned MAX_SIDE = 4096;
  localparam int unsigned SIDE_W   = 13;
  localparam int unsigned CURSOR_W = 25;
  localparam int unsigned TOTAL_W  = 2 * SIDE_W;
  localparam int unsigned START_W  = 24;
  localparam int unsigned LEN_W    = 25;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CHAR_W   = 8;

  localparam logic [SIDE_W-1:0] GRID_RESET = SIDE_W'(64);

  // Configuration register indexes.
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_RUN  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CLIP = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_END  = 2'd2;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_ROW   = 8'h24;
  localparam logic [CHAR_W-1:0] CH_END   = 8'h21;
  localparam logic [CHAR_W-1:0] CH_LIVE  = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_DEAD  = 8'h62;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Commands passed from the parser to the run engine.
  typedef enum logic [1:0] {
    CMD_LIVE,
    CMD_DEAD,
    CMD_ROW,
    CMD_END
  } cmd_op_t;

  localparam int unsigned OP_W = 2;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_ROW,
    BK_LEFT,
    BK_EVAL
  } bk_state_t;

  typedef struct packed {
    logic [START_W-1:0]  run_start;
    logic [LEN_W-1:0]    run_length;
    logic                run_value;
    logic [STATUS_W-1:0] status;
  } result_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] reg_val);
    logic [SIDE_W-1:0] side;
    if (reg_val == '0) begin
      side = SIDE_W'(1);
    end else if (reg_val > SIDE_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = reg_val;
    end
    return side;
  endfunction

endpackage

[sv/lrd_front.sv]
module lrd_front #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            char_valid,
  input  logic [lrd_pkg::CHAR_W-1:0]      char_code,
  output logic                            cmd_push,
  output logic [COUNT_BITS+lrd_pkg::OP_W-1:0] cmd_data
);

  localparam int unsigned ACC_W = COUNT_BITS + 4;

  logic [COUNT_BITS-1:0] acc_r, acc_nxt;
  logic                  seen_r, seen_nxt;
  logic                  line_start_r, line_start_nxt;
  logic                  comment_r, comment_nxt;

  logic                  is_blank, is_digit, is_tag;
  logic [3:0]            digit;
  logic [ACC_W-1:0]      acc10;
  logic [COUNT_BITS-1:0] count_eff;
  lrd_pkg::cmd_op_t      op;

  always_comb begin
    is_blank = (char_code == lrd_pkg::CH_SPACE) || (char_code == lrd_pkg::CH_TAB) ||
               (char_code == lrd_pkg::CH_VT) || (char_code == lrd_pkg::CH_FF) ||
               (char_code == lrd_pkg::CH_CR);
    is_digit = (char_code >= lrd_pkg::CH_ZERO) && (char_code <= lrd_pkg::CH_NINE);
    digit    = 4'(char_code - lrd_pkg::CH_ZERO);
    // Count times ten as a shift-and-add.
    acc10    = (ACC_W'({acc_r, 3'b000}) + ACC_W'({acc_r, 1'b0})) + ACC_W'(digit);
    count_eff = seen_r ? acc_r : COUNT_BITS'(1);

    is_tag = 1'b1;
    op     = lrd_pkg::CMD_END;
    unique case (char_code)
      lrd_pkg::CH_LIVE: op = lrd_pkg::CMD_LIVE;
      lrd_pkg::CH_DEAD: op = lrd_pkg::CMD_DEAD;
      lrd_pkg::CH_ROW:  op = lrd_pkg::CMD_ROW;
      lrd_pkg::CH_END:  op = lrd_pkg::CMD_END;
      default:          is_tag = 1'b0;
    endcase
  end

  always_comb begin
    acc_nxt        = acc_r;
    seen_nxt       = seen_r;
    line_start_nxt = line_start_r;
    comment_nxt    = comment_r;
    cmd_push       = 1'b0;
    if (char_valid) begin
      if (char_code == lrd_pkg::CH_NL) begin
        line_start_nxt = 1'b1;
        comment_nxt    = 1'b0;
        seen_nxt       = 1'b0;
        acc_nxt        = '0;
      end else if (comment_r) begin
        // Rest of a comment line is ignored.
      end else if (line_start_r && is_blank) begin
        // Leading blanks keep the line at its start.
      end else if (line_start_r && (char_code == lrd_pkg::CH_HASH)) begin
        comment_nxt    = 1'b1;
        line_start_nxt = 1'b0;
      end else begin
        line_start_nxt = 1'b0;
        if (is_digit) begin
          seen_nxt = 1'b1;
          if (acc10 > ACC_W'({COUNT_BITS{1'b1}})) begin
            acc_nxt = '1;
          end else begin
            acc_nxt = acc10[COUNT_BITS-1:0];
          end
        end else begin
          seen_nxt = 1'b0;
          acc_nxt  = '0;
          cmd_push = is_tag;
        end
      end
    end
  end

  assign cmd_data = {op, count_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      seen_r       <= 1'b0;
      line_start_r <= 1'b1;
      comment_r    <= 1'b0;
    end else begin
      acc_r        <= acc_nxt;
      seen_r       <= seen_nxt;
      line_start_r <= line_start_nxt;
      comment_r    <= comment_nxt;
    end
  end

endmodule

[sv/lrd_cmd_fifo.sv]
module lrd_cmd_fifo #(
  parameter int unsigned WIDTH = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned CNT_W = 2;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic             wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[sv/lrd_back.sv]
module lrd_back #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [lrd_pkg::SIDE_W-1:0]          grid_width,
  input  logic [lrd_pkg::SIDE_W-1:0]          grid_height,
  input  logic                                cmd_valid,
  input  logic [COUNT_BITS+lrd_pkg::OP_W-1:0] cmd_data,
  output logic                                cmd_pop,
  output logic                                res_valid,
  output lrd_pkg::result_t                    res,
  input  logic                                res_pop
);

  localparam int unsigned SIDE_W   = lrd_pkg::SIDE_W;
  localparam int unsigned CURSOR_W = lrd_pkg::CURSOR_W;
  localparam int unsigned TOTAL_W  = lrd_pkg::TOTAL_W;
  localparam int unsigned PROD_W   = COUNT_BITS + SIDE_W;
  localparam int unsigned REQ_W    = PROD_W + 1;
  localparam int unsigned CMP_W    = (REQ_W > TOTAL_W) ? REQ_W : TOTAL_W;
  localparam int unsigned STEP_W   = $clog2(CURSOR_W);

  lrd_pkg::bk_state_t state_r, state_nxt;
  lrd_pkg::cmd_op_t   op_r, cmd_op;
  logic [COUNT_BITS-1:0] count_r, cmd_count;
  logic [REQ_W-1:0]      req_r;
  logic [PROD_W-1:0]     prod_r;
  logic [CURSOR_W-1:0]   cursor_r, div_r;
  logic [SIDE_W-1:0]     rem_r;
  logic [STEP_W-1:0]     step_r;
  logic [TOTAL_W-1:0]    total_r, left_r;
  logic                  halted_r;
  logic                  res_valid_r;
  lrd_pkg::result_t      res_r;

  logic [SIDE_W-1:0]     w_side, h_side, pad;
  logic [SIDE_W:0]       div_sh;
  logic                  div_ge;
  logic                  emit, res_load;
  logic [CMP_W-1:0]      req_cmp, left_cmp, len_cmp;
  logic                  clip;

  assign cmd_op    = lrd_pkg::cmd_op_t'(cmd_data[COUNT_BITS+lrd_pkg::OP_W-1:COUNT_BITS]);
  assign cmd_count = cmd_data[COUNT_BITS-1:0];
  assign w_side    = lrd_pkg::clamp_side(grid_width);
  assign h_side    = lrd_pkg::clamp_side(grid_height);

  // One restoring step of cursor modulo width.
  assign div_sh = {rem_r, div_r[CURSOR_W-1]};
  assign div_ge = div_sh >= {1'b0, w_side};
  assign pad    = (rem_r != '0) ? (w_side - rem_r) : '0;

  assign req_cmp  = CMP_W'(req_r);
  assign left_cmp = CMP_W'(left_r);
  assign clip     = req_cmp > left_cmp;
  assign len_cmp  = clip ? left_cmp : req_cmp;
  assign emit     = (op_r == lrd_pkg::CMD_END) || (req_r != '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrd_pkg::BK_IDLE: begin
        if (cmd_valid && !halted_r) begin
          state_nxt = (cmd_op == lrd_pkg::CMD_ROW) ? lrd_pkg::BK_DIV : lrd_pkg::BK_LEFT;
        end
      end
      lrd_pkg::BK_DIV: begin
        if (step_r == STEP_W'(CURSOR_W - 1)) begin
          state_nxt = lrd_pkg::BK_ROW;
        end
      end
      lrd_pkg::BK_ROW:  state_nxt = lrd_pkg::BK_LEFT;
      lrd_pkg::BK_LEFT: state_nxt = lrd_pkg::BK_EVAL;
      lrd_pkg::BK_EVAL: begin
        if (!emit || !res_valid_r) begin
          state_nxt = lrd_pkg::BK_IDLE;
        end
      end
      default: state_nxt = lrd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = (state_r == lrd_pkg::BK_IDLE) && cmd_valid;
    res_load = (state_r == lrd_pkg::BK_EVAL) && emit && !res_valid_r;
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    total_r <= TOTAL_W'(w_side) * TOTAL_W'(h_side);
    left_r  <= (TOTAL_W'(cursor_r) < total_r) ? (total_r - TOTAL_W'(cursor_r)) : '0;
    prod_r  <= PROD_W'(count_r - COUNT_BITS'(1)) * PROD_W'(w_side);
    if (cmd_pop) begin
      op_r    <= cmd_op;
      count_r <= cmd_count;
      req_r   <= REQ_W'(cmd_count);
      rem_r   <= '0;
      div_r   <= cursor_r;
      step_r  <= '0;
    end
    if (state_r == lrd_pkg::BK_DIV) begin
      rem_r  <= div_ge ? SIDE_W'(div_sh - {1'b0, w_side}) : div_sh[SIDE_W-1:0];
      div_r  <= {div_r[CURSOR_W-2:0], 1'b0};
      step_r <= step_r + STEP_W'(1);
    end
    if (state_r == lrd_pkg::BK_ROW) begin
      req_r <= REQ_W'(pad) + ((count_r > COUNT_BITS'(1)) ? REQ_W'(prod_r) : '0);
    end
    if (res_load) begin
      res_r.run_start <= cursor_r[lrd_pkg::START_W-1:0];
      if (op_r == lrd_pkg::CMD_END) begin
        res_r.run_length <= '0;
        res_r.run_value  <= 1'b0;
        res_r.status     <= lrd_pkg::STATUS_END;
      end else begin
        res_r.run_length <= len_cmp[lrd_pkg::LEN_W-1:0];
        res_r.run_value  <= (op_r == lrd_pkg::CMD_LIVE);
        res_r.status     <= clip ? lrd_pkg::STATUS_CLIP : lrd_pkg::STATUS_RUN;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrd_pkg::BK_IDLE;
      cursor_r    <= '0;
      halted_r    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) begin
        res_valid_r <= 1'b1;
        if (op_r == lrd_pkg::CMD_END) begin
          halted_r <= 1'b1;
        end else begin
          cursor_r <= cursor_r + len_cmp[CURSOR_W-1:0];
          if (clip) begin
            halted_r <= 1'b1;
          end
        end
      end else if (res_pop && res_valid_r) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

[sv/life_rle_pattern_decoder_top.sv]
// Channel   Ports                                    Moves
// input     in_push, in_full, in_char_code           one pattern body byte per request
// result    out_pop, out_empty, out_run_*, out_status one run or end mark per request
// config    cfg_we, cfg_index, cfg_wdata             grid width (0) or grid height (1)
//
// The parser takes one byte per cycle while the command queue has room; digits, blanks
// and comment text cost nothing more. An 'o' or 'b' takes the run engine through LEFT
// and EVAL; a '$' first runs the 25-step width divider for the cursor column, then ROW.
// Reset is synchronous and active low; it needs no clearing pass.
// A two-entry command queue lets the parser keep taking bytes while a run waits on pop.

module life_rle_pattern_decoder_top #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_push,
  output logic                             in_full,
  input  logic [lrd_pkg::CHAR_W-1:0]       in_char_code,

  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [lrd_pkg::START_W-1:0]      out_run_start,
  output logic [lrd_pkg::LEN_W-1:0]        out_run_length,
  output logic                             out_run_value,
  output logic [lrd_pkg::STATUS_W-1:0]     out_status,

  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [lrd_pkg::SIDE_W-1:0]       cfg_wdata
);

  localparam int unsigned CMD_W = COUNT_BITS + lrd_pkg::OP_W;

  logic [lrd_pkg::SIDE_W-1:0] grid_width_r, grid_height_r;
  logic                       char_valid;
  logic                       cmd_push, cmd_valid, cmd_pop;
  logic [CMD_W-1:0]           cmd_in, cmd_out;
  logic                       res_valid;
  lrd_pkg::result_t           res;

  // Configuration registers; to be written only while the block is idle (not enforced).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= lrd_pkg::GRID_RESET;
      grid_height_r <= lrd_pkg::GRID_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lrd_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        lrd_pkg::CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A byte is taken whenever the command queue has room, since any byte can be a tag.
  assign char_valid = in_push && !in_full;

  lrd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_valid(char_valid),
    .char_code (in_char_code),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in)
  );

  lrd_cmd_fifo #(
    .WIDTH(CMD_W)
  ) u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd_in),
    .full     (in_full),
    .pop      (cmd_pop),
    .valid    (cmd_valid),
    .pop_data (cmd_out)
  );

  // The run engine owns the cursor and the halt flag, and drops commands once halted.
  lrd_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .grid_width (grid_width_r),
    .grid_height(grid_height_r),
    .cmd_valid  (cmd_valid),
    .cmd_data   (cmd_out),
    .cmd_pop    (cmd_pop),
    .res_valid  (res_valid),
    .res        (res),
    .res_pop    (out_pop)
  );

  assign out_empty      = !res_valid;
  assign out_run_start  = res.run_start;
  assign out_run_length = res.run_length;
  assign out_run_value  = res.run_value;
  assign out_status     = res.status;

endmodule

[verif/life_rle_pattern_decoder_top_tb.sv]
module life_rle_pattern_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SIDE_W   = lrd_pkg::SIDE_W;
  localparam int unsigned CURSOR_W = lrd_pkg::CURSOR_W;
  localparam int unsigned CHAR_W   = lrd_pkg::CHAR_W;
  localparam int unsigned START_W  = lrd_pkg::START_W;
  localparam int unsigned LEN_W    = lrd_pkg::LEN_W;
  localparam int unsigned STATUS_W = lrd_pkg::STATUS_W;

  // The decoder is built with the default count width; the tb mirrors it so
  // that its own saturation point matches.
  localparam int unsigned COUNT_BITS = 24;
  localparam longint unsigned COUNT_CEIL = (64'd1 << COUNT_BITS) - 64'd1;

  // A long receiver hold-off, used once, so the result side backs up into in_full.
  localparam int unsigned HOLD_CYCLES   = 400;
  // Quiet time after the last expected run before a register write or the end.
  // Up to three commands that give no run can still be in the block, and a
  // '$' that pads nothing still goes through the width divider.
  localparam int unsigned SETTLE_CYCLES = 128;
  localparam int unsigned FINAL_WAIT    = 5000;
  localparam int unsigned CYCLE_LIMIT   = 500000;

  localparam int unsigned DIRECTED_ROWS = 29;

  // Decoder state as the tb tracks it, registers included.
  typedef struct packed {
    logic [SIDE_W-1:0]     width_reg;
    logic [SIDE_W-1:0]     height_reg;
    logic [CURSOR_W-1:0]   cursor;
    logic [COUNT_BITS-1:0] count;
    logic                  count_seen;
    logic                  line_start;
    logic                  in_comment;
    logic                  halted;
  } decoder_state_t;

  // One directed byte; want_given marks rows whose run is written out by hand.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              want_given;
    lrd_pkg::result_t  want;
  } stim_row_t;

  // How the pattern is brought to a halt at the very end of the run.
  typedef enum logic [1:0] {
    FINISH_END_MARK,
    FINISH_OVERFLOW_CLIP,
    FINISH_SHRUNK_GRID
  } finish_kind_t;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_push      = 1'b0;
  logic                 in_full;
  logic [CHAR_W-1:0]    in_char_code = '0;
  logic                 out_empty;
  logic                 out_pop      = 1'b0;
  logic [START_W-1:0]   out_run_start;
  logic [LEN_W-1:0]     out_run_length;
  logic                 out_run_value;
  logic [STATUS_W-1:0]  out_status;
  logic                 cfg_we       = 1'b0;
  logic                 cfg_index    = lrd_pkg::CFG_GRID_WIDTH;
  logic [SIDE_W-1:0]    cfg_wdata    = '0;

  decoder_state_t       dec;
  lrd_pkg::result_t     expected_runs[$];
  int unsigned          errors       = 0;
  int unsigned          burst_left   = 0;
  int unsigned          chars_sent   = 0;
  longint unsigned      cursor_cap   = 0;
  bit                   steady       = 1'b0;
  bit                   hold_wanted  = 1'b0;

  // Directed bytes under the reset grid of 64 x 64. The first two runs come
  // straight after reset and are written out; the rest go through the predictor.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{lrd_pkg::CH_LIVE,  1'b1, '{24'd0, 25'd1, 1'b1, lrd_pkg::STATUS_RUN}},
    '{lrd_pkg::CH_DEAD,  1'b1, '{24'd1, 25'd1, 1'b0, lrd_pkg::STATUS_RUN}},
    '{8'h33,             1'b0, '0},   // count of three ...
    '{lrd_pkg::CH_LIVE,  1'b0, '0},   // ... applied to a live run
    '{lrd_pkg::CH_ZERO,  1'b0, '0},   // explicit zero count on a live tag: no run
    '{lrd_pkg::CH_LIVE,  1'b0, '0},
    '{lrd_pkg::CH_ZERO,  1'b0, '0},   // zero count on a row end acts as one: pads the row
    '{lrd_pkg::CH_ROW,   1'b0, '0},
    '{lrd_pkg::CH_ROW,   1'b0, '0},   // already at column zero: nothing to pad
    '{8'h32,             1'b0, '0},
    '{lrd_pkg::CH_ROW,   1'b0, '0},   // one whole dead row
    '{8'h37,             1'b0, '0},   // count dropped by the newline
    '{lrd_pkg::CH_NL,    1'b0, '0},
    '{lrd_pkg::CH_SPACE, 1'b0, '0},   // blanks keep the line at its start
    '{lrd_pkg::CH_TAB,   1'b0, '0},
    '{lrd_pkg::CH_VT,    1'b0, '0},
    '{lrd_pkg::CH_FF,    1'b0, '0},
    '{lrd_pkg::CH_CR,    1'b0, '0},
    '{lrd_pkg::CH_HASH,  1'b0, '0},   // comment line: the end mark and tag below are text
    '{lrd_pkg::CH_END,   1'b0, '0},
    '{lrd_pkg::CH_LIVE,  1'b0, '0},
    '{lrd_pkg::CH_NL,    1'b0, '0},
    '{8'h00,             1'b0, '0},   // lowest byte, just noise
    '{lrd_pkg::CH_NINE,  1'b0, '0},
    '{8'hFF,             1'b0, '0},   // highest byte drops the pending count
    '{lrd_pkg::CH_DEAD,  1'b0, '0},
    '{lrd_pkg::CH_HASH,  1'b0, '0},   // '#' in mid-line is not a comment
    '{lrd_pkg::CH_NINE,  1'b0, '0},
    '{lrd_pkg::CH_LIVE,  1'b0, '0}
  };

  life_rle_pattern_decoder_top #(
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_char_code  (in_char_code),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_run_start (out_run_start),
    .out_run_length(out_run_length),
    .out_run_value (out_run_value),
    .out_status    (out_status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Grid side as the decoder uses it: a zero register counts as one and
  // anything beyond the largest side is held at that side.
  function automatic longint unsigned side_cells(input logic [SIDE_W-1:0] reg_val);
    if (reg_val == '0) return 64'd1;
    if (reg_val > lrd_pkg::MAX_SIDE) return 64'(lrd_pkg::MAX_SIDE);
    return 64'(reg_val);
  endfunction

  // Advances the decoder state by one body byte. Returns 1 when the byte
  // produces a run (or the end mark), which is then placed in run.
  function automatic bit decode_char(inout decoder_state_t s, input logic [CHAR_W-1:0] c,
                                     output lrd_pkg::result_t run);
    longint unsigned w;
    longint unsigned h;
    longint unsigned total;
    longint unsigned left;
    longint unsigned req;
    longint unsigned cnt;
    longint unsigned acc;
    longint unsigned col;
    logic            value;
    run = '0;
    if (s.halted) return 1'b0;
    if (c == lrd_pkg::CH_NL) begin
      s.line_start = 1'b1;
      s.in_comment = 1'b0;
      s.count_seen = 1'b0;
      s.count      = '0;
      return 1'b0;
    end
    if (s.in_comment) return 1'b0;
    if (s.line_start && (c == lrd_pkg::CH_SPACE || c == lrd_pkg::CH_TAB ||
                         c == lrd_pkg::CH_VT || c == lrd_pkg::CH_FF ||
                         c == lrd_pkg::CH_CR)) begin
      return 1'b0;
    end
    if (s.line_start && c == lrd_pkg::CH_HASH) begin
      s.in_comment = 1'b1;
      s.line_start = 1'b0;
      return 1'b0;
    end
    s.line_start = 1'b0;

    if (c >= lrd_pkg::CH_ZERO && c <= lrd_pkg::CH_NINE) begin
      acc = 64'(s.count) * 64'd10 + 64'(c - lrd_pkg::CH_ZERO);
      if (acc > COUNT_CEIL) acc = COUNT_CEIL;
      s.count      = COUNT_BITS'(acc);
      s.count_seen = 1'b1;
      return 1'b0;
    end

    // Any other byte uses up the pending count, if there is one.
    cnt = s.count_seen ? 64'(s.count) : 64'd1;
    s.count_seen = 1'b0;
    s.count      = '0;
    w = side_cells(s.width_reg);
    h = side_cells(s.height_reg);

    case (c)
      lrd_pkg::CH_LIVE: begin
        req   = cnt;
        value = 1'b1;
      end
      lrd_pkg::CH_DEAD: begin
        req   = cnt;
        value = 1'b0;
      end
      lrd_pkg::CH_ROW: begin
        col   = 64'(s.cursor) % w;
        req   = (col != 0) ? w - col : 64'd0;
        if (cnt > 1) req += (cnt - 1) * w;
        value = 1'b0;
      end
      lrd_pkg::CH_END: begin
        run.run_start  = s.cursor[START_W-1:0];
        run.run_length = '0;
        run.run_value  = 1'b0;
        run.status     = lrd_pkg::STATUS_END;
        s.halted       = 1'b1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase

    if (req == 0) return 1'b0;
    total = w * h;
    left  = (64'(s.cursor) < total) ? total - 64'(s.cursor) : 64'd0;
    run.run_start = s.cursor[START_W-1:0];
    run.run_value = value;
    if (req > left) begin
      // Runs past the grid end are cut, flagged, and stop the decoder.
      run.run_length = LEN_W'(left);
      run.status     = lrd_pkg::STATUS_CLIP;
      s.cursor       = CURSOR_W'(64'(s.cursor) + left);
      s.halted       = 1'b1;
    end else begin
      run.run_length = LEN_W'(req);
      run.status     = lrd_pkg::STATUS_RUN;
      s.cursor       = CURSOR_W'(64'(s.cursor) + req);
    end
    return 1'b1;
  endfunction

  function automatic logic [CHAR_W-1:0] any_blank();
    case ($urandom_range(0, 4))
      0:       return lrd_pkg::CH_SPACE;
      1:       return lrd_pkg::CH_TAB;
      2:       return lrd_pkg::CH_VT;
      3:       return lrd_pkg::CH_FF;
      default: return lrd_pkg::CH_CR;
    endcase
  endfunction

  // Puts one byte on the input side (entered at a falling edge) and waits for
  // the request to be taken. The expected run, if any, is queued at the next
  // falling edge so it never meets the result check in the same time step.
  // Between requests the sender works in bursts with random gaps, except while steady is set.
  task automatic send_char(input logic [CHAR_W-1:0] code, input logic want_given,
                           input lrd_pkg::result_t want);
    lrd_pkg::result_t run;
    in_push      <= 1'b1;
    in_char_code <= code;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
    if (decode_char(dec, code, run)) expected_runs.push_back(want_given ? want : run);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  endtask

  // Random bytes must not stop the decoder before the end of the run, and each
  // phase keeps the cursor below its cap so later grids still have room. A byte
  // that would break either rule is replaced by a newline.
  task automatic offer_char(input logic [CHAR_W-1:0] code);
    decoder_state_t   trial;
    lrd_pkg::result_t run;
    trial = dec;
    if (decode_char(trial, code, run) &&
        (run.status != lrd_pkg::STATUS_RUN || 64'(trial.cursor) > cursor_cap)) begin
      code = lrd_pkg::CH_NL;
    end
    send_char(code, 1'b0, '0);
    chars_sent++;
  endtask

  // Decimal count, now and then with a leading zero.
  task automatic offer_count(input longint unsigned n);
    string digits;
    digits = $sformatf("%0d", n);
    if ($urandom_range(0, 7) == 0) offer_char(lrd_pkg::CH_ZERO);
    for (int i = 0; i < digits.len(); i++) offer_char(digits[i]);
  endtask

  // One short stretch of pattern text. Most of it is well formed: counts and
  // tags, row ends, comment lines. The rest is blanks, counts that lead
  // nowhere (some long enough to saturate) and arbitrary bytes.
  task automatic offer_token();
    int unsigned       kind;
    int unsigned       pick;
    longint unsigned   room;
    longint unsigned   w;
    logic [CHAR_W-1:0] b;
    room = (cursor_cap > 64'(dec.cursor)) ? cursor_cap - 64'(dec.cursor) : 64'd0;
    w    = side_cells(dec.width_reg);
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    if (kind < 45) begin
      if (pick < 6) offer_count($urandom_range(1, 20));
      else if (pick < 8) offer_count($urandom_range(0, 2));
      else if (pick < 9) offer_count($urandom_range(0, 32'(room / 8)));
      offer_char($urandom_range(0, 1) ? lrd_pkg::CH_LIVE : lrd_pkg::CH_DEAD);
    end else if (kind < 62) begin
      if (pick >= 4 && pick < 8) offer_count($urandom_range(0, 3));
      else if (pick >= 8) offer_count($urandom_range(0, 32'(room / (8 * w)) + 1));
      offer_char(lrd_pkg::CH_ROW);
    end else if (kind < 72) begin
      offer_char(lrd_pkg::CH_NL);
    end else if (kind < 80) begin
      offer_char(lrd_pkg::CH_NL);
      repeat ($urandom_range(0, 2)) offer_char(any_blank());
      offer_char(lrd_pkg::CH_HASH);
      repeat ($urandom_range(1, 5)) offer_char(8'($urandom_range(0, 255)));
      offer_char(lrd_pkg::CH_NL);
    end else if (kind < 86) begin
      offer_char(any_blank());
    end else if (kind < 94) begin
      if (pick < 3) begin
        repeat ($urandom_range(8, 14)) begin
          offer_char(8'(lrd_pkg::CH_ZERO + $urandom_range(0, 9)));
        end
      end else begin
        offer_count($urandom_range(0, 999));
      end
      do begin
        b = 8'($urandom_range(0, 255));
      end while ((b >= lrd_pkg::CH_ZERO && b <= lrd_pkg::CH_NINE) ||
                 b == lrd_pkg::CH_LIVE || b == lrd_pkg::CH_DEAD ||
                 b == lrd_pkg::CH_ROW || b == lrd_pkg::CH_END);
      offer_char(b);
    end else begin
      offer_char(8'($urandom_range(0, 255)));
    end
  endtask

  // Stops offering and waits until every expected run has been taken, then
  // lets any commands that give no run finish inside the block.
  task automatic drain_results();
    in_push <= 1'b0;
    while (expected_runs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write, entered and left at a falling edge; the trailing wait keeps
  // back-to-back writes from raising and lowering cfg_we in one time step.
  task automatic write_grid(input logic idx, input logic [SIDE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == lrd_pkg::CFG_GRID_WIDTH) dec.width_reg = value;
    else dec.height_reg = value;
    @(negedge clk);
  endtask

  // Drain, then one grid setting and random text until at least the given number of bytes.
  task automatic run_phase(input logic [SIDE_W-1:0] width, input logic [SIDE_W-1:0] height,
                           input int unsigned chars, input longint unsigned cap);
    drain_results();
    write_grid(lrd_pkg::CFG_GRID_WIDTH, width);
    write_grid(lrd_pkg::CFG_GRID_HEIGHT, height);
    cursor_cap = cap;
    chars_sent = 0;
    while (chars_sent < chars) offer_token();
  endtask

  task automatic check_field(input string name, input logic [LEN_W-1:0] want,
                             input logic [LEN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result side: every run taken by a pop request is compared with the oldest
  // expected run, field by field.
  always @(posedge clk) begin : result_check
    lrd_pkg::result_t oldest;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_runs.size() == 0) begin
        $error("run with none expected: start %0d, length %0d, value %0d, status %0d",
               out_run_start, out_run_length, out_run_value, out_status);
        errors++;
      end else begin
        oldest = expected_runs.pop_front();
        check_field("run_start", LEN_W'(oldest.run_start), LEN_W'(out_run_start));
        check_field("run_length", oldest.run_length, out_run_length);
        check_field("run_value", LEN_W'(oldest.run_value), LEN_W'(out_run_value));
        check_field("status", LEN_W'(oldest.status), LEN_W'(out_status));
      end
    end
  end

  // Receiver: pop follows a periodic stall pattern that is redrawn every
  // window; some windows have no stalls at all. Once, on request from the
  // stimulus, pop stays low for a long stretch so the block backs up.
  initial begin : result_sink
    int unsigned window;
    int unsigned period;
    int unsigned stall_len;
    int unsigned step;
    bit          hold_done;
    window    = 0;
    period    = 1;
    stall_len = 0;
    step      = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !hold_done) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (window == 0) begin
        window    = $urandom_range(16, 96);
        period    = $urandom_range(2, 9);
        stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, period - 1);
        step      = 0;
      end
      out_pop <= ((step % period) >= stall_len);
      step++;
      window--;
    end
  end

  // Ends a run that hangs; a correct run uses a small part of this.
  initial begin : watchdog
    int unsigned cycles_run;
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    finish_kind_t finish_kind;
    int unsigned  waited;
    dec            = '0;
    dec.width_reg  = lrd_pkg::GRID_RESET;
    dec.height_reg = lrd_pkg::GRID_RESET;
    dec.line_start = 1'b1;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed bytes on the reset grid.
    cursor_cap = 64'hFFFF_FFFF;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_char(directed_rows[i].code, directed_rows[i].want_given, directed_rows[i].want);
    end

    // The cursor only moves forward and there is one reset, so the grids go
    // from small to large and each phase leaves room for the next. Extremes
    // of both registers come first: one full-width row, then a one-cell-wide
    // column with an out-of-range height, a zero width standing for one.
    run_phase(13'd4096, 13'd0, 100, 64'd1500);
    run_phase(13'd0, 13'd8191, 100, 64'd3000);
    steady = 1'b1;
    run_phase(13'd7, 13'd1000, 100, 64'd6000);
    steady = 1'b0;
    // The receiver holds off during this phase while bytes keep coming; the
    // earlier runs are drained first so the hold-off falls on new traffic.
    drain_results();
    hold_wanted = 1'b1;
    run_phase(13'd100, 13'd300, 120, 64'd25000);
    run_phase(13'd4096, 13'd4096, 150, 64'd8000000);
    run_phase(13'd8191, 13'd8191, 130, 64'd16000000);

    // Halting is final until reset, so each run ends in one of three ways:
    // the end mark, a saturated count clipped at the grid end, or a grid
    // shrunk below the cursor so a run finds no cells left.
    drain_results();
    finish_kind = finish_kind_t'($urandom_range(0, 2));
    if (finish_kind == FINISH_SHRUNK_GRID) begin
      write_grid(lrd_pkg::CFG_GRID_WIDTH, 13'd1);
      write_grid(lrd_pkg::CFG_GRID_HEIGHT, 13'd1);
    end
    send_char(lrd_pkg::CH_NL, 1'b0, '0);
    case (finish_kind)
      FINISH_END_MARK: send_char(lrd_pkg::CH_END, 1'b0, '0);
      FINISH_OVERFLOW_CLIP: begin
        repeat (11) send_char(lrd_pkg::CH_NINE, 1'b0, '0);
        send_char(lrd_pkg::CH_LIVE, 1'b0, '0);
      end
      default: send_char(lrd_pkg::CH_DEAD, 1'b0, '0);
    endcase
    // Nothing after the halt may produce a run.
    send_char(lrd_pkg::CH_LIVE, 1'b0, '0);
    send_char(lrd_pkg::CH_ROW, 1'b0, '0);
    send_char(lrd_pkg::CH_END, 1'b0, '0);
    repeat (8) send_char(8'($urandom_range(0, 255)), 1'b0, '0);
    in_push <= 1'b0;

    waited = 0;
    while (expected_runs.size() != 0 && waited < FINAL_WAIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_runs.size() != 0) begin
      $error("%0d expected runs never arrived", expected_runs.size());
      errors++;
    end

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
sv/lrd_pkg.sv
sv/lrd_front.sv
sv/lrd_cmd_fifo.sv
sv/lrd_back.sv
sv/life_rle_pattern_decoder_top.sv
verif/life_rle_pattern_decoder_top_tb.sv
